// ===== rtl/core/eci_pkg.sv =====
// Shared constants, codes and curve tables for the easing curve interpolator.
`default_nettype none

package eci_pkg;

  localparam int PHASE_FRAC_BITS = 16;
  localparam int COORD_BITS      = 12;
  localparam int TABLE_BITS      = 10;

  localparam int TW       = PHASE_FRAC_BITS + 1;
  localparam int CB       = COORD_BITS;
  localparam int TAB_N    = 1 << TABLE_BITS;
  localparam int SIDX_W   = TABLE_BITS + 1;
  localparam int IDX_DOWN = (PHASE_FRAC_BITS >= TABLE_BITS) ? PHASE_FRAC_BITS - TABLE_BITS : 0;
  localparam int IDX_UP   = (PHASE_FRAC_BITS >= TABLE_BITS) ? 0 : TABLE_BITS - PHASE_FRAC_BITS;

  localparam int OP_W       = 3;
  localparam int REG_IDX_W  = 2;
  localparam int IN_DATA_W  = ((TW + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TW + 2 * CB + 7) / 8) * 8;

  localparam logic [TW-1:0] F_ONE  = TW'(1) << PHASE_FRAC_BITS;
  localparam logic [TW-1:0] F_HALF = F_ONE >> 1;

  localparam logic [TW-1:0] OFF_3_4   = TW'((3 * (1 << PHASE_FRAC_BITS)) / 4);
  localparam logic [TW-1:0] OFF_15_16 = TW'((15 * (1 << PHASE_FRAC_BITS)) / 16);
  localparam logic [TW-1:0] OFF_63_64 = TW'((63 * (1 << PHASE_FRAC_BITS)) / 64);

  localparam logic [CB-1:0] RST_START_X = CB'(100);
  localparam logic [CB-1:0] RST_START_Y = CB'(100);
  localparam logic [CB-1:0] RST_END_X   = CB'(874);
  localparam logic [CB-1:0] RST_END_Y   = CB'(100);

  typedef enum logic [OP_W-1:0] {
    OP_LINEAR     = 3'd0,
    OP_IN_QUINT   = 3'd1,
    OP_OUT_SINE   = 3'd2,
    OP_IN_SINE    = 3'd3,
    OP_OUT_EXPO   = 3'd4,
    OP_OUT_BOUNCE = 3'd5
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEG_FIRST  = 2'd0,
    SEG_SECOND = 2'd1,
    SEG_THIRD  = 2'd2,
    SEG_LAST   = 2'd3
  } bnc_seg_t;

  // Q4.60 series used to fill the tables at elaboration
  localparam int QB = 60;
  localparam logic [63:0] Q_ONE     = 64'd1 << QB;
  localparam logic [63:0] Q_HALF_PI = 64'h1921FB54442D1847;
  localparam logic [63:0] Q_LN2     = 64'h0B17217F7D1CF79B;

  localparam logic [63:0] SIN_DIV [1:15] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
  };
  localparam logic [63:0] EXP_DIV [1:20] = '{
    64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8, 64'd9, 64'd10,
    64'd11, 64'd12, 64'd13, 64'd14, 64'd15, 64'd16, 64'd17, 64'd18, 64'd19, 64'd20
  };

  typedef logic [TW-1:0] sine_rom_t [0:TAB_N];
  typedef logic [TW-1:0] expo_rom_t [0:TAB_N-1];

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> QB);
  endfunction

  function automatic logic [63:0] round_q(logic [63:0] v, int unsigned extra);
    int unsigned sh;
    sh = QB - PHASE_FRAC_BITS + extra;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic logic [TW-1:0] sine_entry(int unsigned j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = qmul(Q_HALF_PI, 64'(j) << (QB - TABLE_BITS));
    x2   = qmul(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 15; k++) begin
      term = qmul(term, x2) / SIN_DIV[k];
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return TW'(round_q(sum, 0));
  endfunction

  function automatic logic [TW-1:0] expo_entry(int unsigned i);
    logic [63:0] v;
    logic [63:0] fr;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    int unsigned n;
    v    = 64'(10 * i);
    n    = 32'(v >> TABLE_BITS);
    fr   = v & 64'(TAB_N - 1);
    z    = qmul(Q_LN2, fr << (QB - TABLE_BITS));
    term = Q_ONE;
    sum  = Q_ONE;
    for (int k = 1; k <= 20; k++) begin
      term = qmul(term, z) / EXP_DIV[k];
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return TW'(round_q(sum, n));
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int j = 0; j <= TAB_N; j++) begin
      r[j] = sine_entry(j);
    end
    return r;
  endfunction

  function automatic expo_rom_t build_expo_rom();
    expo_rom_t r;
    for (int i = 0; i < TAB_N; i++) begin
      r[i] = expo_entry(i);
    end
    return r;
  endfunction

  // sin(pi/2 * j/N) for j = 0..N, and 2^(-10 i/N) for i = 0..N-1, in Q1.F
  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam expo_rom_t EXPO_ROM = build_expo_rom();

endpackage

`default_nettype wire

// ===== rtl/core/easing_curve_interpolator.sv =====
// Throughput: one word per cycle unless m_tready stalls the output; six stages
// plus the output register, each with its own valid bit, so bubbles close up
// and a stall backs up stage by stage. The sine and exponent tables are read once
// per word, registered in stage two.
// Reset (rst, synchronous) empties the pipeline and reloads the point registers.
`default_nettype none

module easing_curve_interpolator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [eci_pkg::IN_DATA_W-1:0]    s_tdata,   // phase
  input  logic [eci_pkg::OP_W-1:0]         s_tuser,   // operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [eci_pkg::OUT_DATA_W-1:0]   m_tdata,   // eased, pos_x, pos_y
  input  logic                             cfg_wen,
  input  logic [eci_pkg::REG_IDX_W-1:0]    cfg_addr,
  input  logic [eci_pkg::CB-1:0]           cfg_wdata
);
  import eci_pkg::*;

  localparam int FB  = PHASE_FRAC_BITS;
  localparam int IWW = ((PHASE_FRAC_BITS > TABLE_BITS) ? PHASE_FRAC_BITS : TABLE_BITS) + 1;
  localparam int BW  = FB + 6;
  localparam int DW  = FB + 3;
  localparam int SQW = 2 * DW;
  localparam int PW  = CB + TW;

  localparam logic [BW-1:0] B4  = BW'(4) << FB;
  localparam logic [BW-1:0] B6  = BW'(6) << FB;
  localparam logic [BW-1:0] B8  = BW'(8) << FB;
  localparam logic [BW-1:0] B9  = BW'(9) << FB;
  localparam logic [BW-1:0] B10 = BW'(10) << FB;
  localparam logic [BW-1:0] B21 = BW'(21) << FB;
  localparam logic [SQW:0]  BR_NEAR = (SQW + 1)'(1) << (FB + 3);
  localparam logic [SQW:0]  BR_LAST = (SQW + 1)'(1) << (FB + 5);

  function automatic logic [TW-1:0] qstep(logic [TW-1:0] a, logic [TW-1:0] b);
    logic [2*TW-1:0] p;
    p = (2 * TW)'(a) * (2 * TW)'(b) + (2 * TW)'(F_HALF);
    return p[FB +: TW];
  endfunction

  // point registers
  logic [CB-1:0] start_x, start_y, end_x, end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= RST_START_X;
      start_y <= RST_START_Y;
      end_x   <= RST_END_X;
      end_y   <= RST_END_Y;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_START_X: start_x <= cfg_wdata;
        REG_START_Y: start_y <= cfg_wdata;
        REG_END_X:   end_x   <= cfg_wdata;
        REG_END_Y:   end_y   <= cfg_wdata;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic [6:1] v;
  logic [6:1] en;
  logic       en_out;

  assign en_out   = !m_tvalid || m_tready;
  assign en[6]    = !v[6] || en_out;
  assign en[5]    = !v[5] || en[6];
  assign en[4]    = !v[4] || en[5];
  assign en[3]    = !v[3] || en[4];
  assign en[2]    = !v[2] || en[3];
  assign en[1]    = !v[1] || en[2];
  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (en[1]) v[1] <= s_tvalid;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
      if (en_out) m_tvalid <= v[6];
    end
  end

  // input decode
  logic [TW-1:0]     phase_in, t_in;
  logic [IWW-1:0]    idx_wide;
  logic [SIDX_W-1:0] idx_in, sidx_in;
  op_t               op_in;

  always_comb begin
    phase_in = s_tdata[TW-1:0];
    t_in     = (phase_in > F_ONE) ? F_ONE : phase_in;
    idx_wide = (IWW'(t_in) >> IDX_DOWN) << IDX_UP;
    idx_in   = idx_wide[SIDX_W-1:0];
    op_in    = op_t'(s_tuser);
    // in_sine reads the mirrored entry, which is the cosine
    sidx_in  = (op_in == OP_IN_SINE) ? SIDX_W'(TAB_N) - idx_in : idx_in;
  end

  // stage 1
  op_t                 op1;
  logic [TW-1:0]       t1;
  logic [SIDX_W-1:0]   sidx1;
  logic [TABLE_BITS-1:0] eidx1;
  logic                one1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op1   <= op_in;
      t1    <= t_in;
      sidx1 <= sidx_in;
      eidx1 <= idx_in[TABLE_BITS-1:0];
      one1  <= (t_in == F_ONE);
    end
  end

  // bounce segment and distance from the segment center
  logic [BW-1:0] t11, t22, dwide;
  bnc_seg_t      seg_s1;

  always_comb begin
    t11 = BW'(t1) * BW'(11);
    t22 = t11 << 1;
    if (t11 < B4) begin
      seg_s1 = SEG_FIRST;
      dwide  = t11;
    end else if (t11 < B8) begin
      seg_s1 = SEG_SECOND;
      dwide  = (t11 >= B6) ? t11 - B6 : B6 - t11;
    end else if (t11 < B10) begin
      seg_s1 = SEG_THIRD;
      dwide  = (t11 >= B9) ? t11 - B9 : B9 - t11;
    end else begin
      seg_s1 = SEG_LAST;
      dwide  = (t22 >= B21) ? t22 - B21 : B21 - t22;
    end
  end

  // stage 2: table reads, first quint step
  op_t           op2;
  logic [TW-1:0] t2, srom2, erom2, q2;
  logic          one2;
  logic [DW-1:0] d2;
  bnc_seg_t      seg2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      op2   <= op1;
      t2    <= t1;
      one2  <= one1;
      srom2 <= SINE_ROM[sidx1];
      erom2 <= EXPO_ROM[eidx1];
      q2    <= qstep(t1, t1);
      d2    <= dwide[DW-1:0];
      seg2  <= seg_s1;
    end
  end

  // stage 3
  op_t            op3;
  logic [TW-1:0]  t3, srom3, erom3, q3;
  logic           one3;
  logic [SQW-1:0] sq3;
  bnc_seg_t       seg3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      op3   <= op2;
      t3    <= t2;
      one3  <= one2;
      srom3 <= srom2;
      erom3 <= erom2;
      q3    <= qstep(q2, t2);
      sq3   <= SQW'(d2) * SQW'(d2);
      seg3  <= seg2;
    end
  end

  // bounce: round the square, add the segment floor
  logic [SQW:0]  bsum;
  logic [TW-1:0] boff, bnc_s3;

  always_comb begin
    case (seg3)
      SEG_FIRST:  boff = '0;
      SEG_SECOND: boff = OFF_3_4;
      SEG_THIRD:  boff = OFF_15_16;
      default:    boff = OFF_63_64;
    endcase
    if (seg3 == SEG_LAST) begin
      bsum   = (SQW + 1)'(sq3) + BR_LAST;
      bnc_s3 = TW'(bsum >> (FB + 6)) + boff;
    end else begin
      bsum   = (SQW + 1)'(sq3) + BR_NEAR;
      bnc_s3 = TW'(bsum >> (FB + 4)) + boff;
    end
  end

  // stage 4
  op_t           op4;
  logic [TW-1:0] t4, srom4, erom4, q4, bnc4;
  logic          one4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      op4   <= op3;
      t4    <= t3;
      one4  <= one3;
      srom4 <= srom3;
      erom4 <= erom3;
      q4    <= qstep(q3, t3);
      bnc4  <= bnc_s3;
    end
  end

  // curve select
  logic [TW-1:0] scl, ecl, e_sel, e_s4;

  always_comb begin
    scl = (srom4 > F_ONE) ? F_ONE : srom4;
    ecl = (erom4 > F_ONE) ? F_ONE : erom4;
    case (op4)
      OP_IN_QUINT:   e_sel = qstep(q4, t4);
      OP_OUT_SINE:   e_sel = srom4;
      OP_IN_SINE:    e_sel = F_ONE - scl;
      OP_OUT_EXPO:   e_sel = one4 ? F_ONE : F_ONE - ecl;
      OP_OUT_BOUNCE: e_sel = bnc4;
      default:       e_sel = t4;
    endcase
    e_s4 = (e_sel > F_ONE) ? F_ONE : e_sel;
  end

  // stage 5
  logic [TW-1:0] e5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      e5 <= e_s4;
    end
  end

  // stage 6: blend products
  logic [TW-1:0] e6;
  logic [PW-1:0] pax6, pbx6, pay6, pby6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      e6   <= e5;
      pax6 <= PW'(start_x) * PW'(F_ONE - e5);
      pbx6 <= PW'(end_x) * PW'(e5);
      pay6 <= PW'(start_y) * PW'(F_ONE - e5);
      pby6 <= PW'(end_y) * PW'(e5);
    end
  end

  // output register
  logic [PW:0]   sum_x, sum_y;
  logic [TW-1:0] eased;
  logic [CB-1:0] pos_x, pos_y;

  assign sum_x = (PW + 1)'(pax6) + (PW + 1)'(pbx6) + (PW + 1)'(F_HALF);
  assign sum_y = (PW + 1)'(pay6) + (PW + 1)'(pby6) + (PW + 1)'(F_HALF);

  always_ff @(posedge clk) begin
    if (en_out) begin
      eased <= e6;
      pos_x <= sum_x[FB +: CB];
      pos_y <= sum_y[FB +: CB];
    end
  end

  assign m_tdata = OUT_DATA_W'({pos_y, pos_x, eased});

`ifndef NO_ASSERTIONS
  a_stall_only_downstream: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled while output side can move");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !v[1] && !v[6]))
    else $error("pipeline not empty after reset");

  a_eased_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (eased <= F_ONE))
    else $error("eased fraction above one");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v[1] && !en[2]) |=> (v[1] && $stable(t1) && $stable(sidx1)))
    else $error("stage 1 word lost during stall");
`endif

endmodule

`default_nettype wire
